// File: rtl/ftws_pkg.sv
package ftws_pkg;

  localparam int unsigned NumTones    = 4;
  localparam int unsigned CyclesWidth = 8;
  localparam int unsigned GainWidth   = 15;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned DivNumWidth = 50;
  localparam int unsigned DivDenWidth = 34;
  localparam int unsigned DivQWidth   = 16;
  localparam int unsigned SampleWidth = 18;

  typedef struct packed {
    logic                   start;
    logic [DivNumWidth-1:0] dividend;
    logic [DivDenWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DivQWidth-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/ftws_ram.sv
module ftws_ram #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/ftws_div.sv
module ftws_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftws_pkg::div_req_t  req_i,
  output ftws_pkg::div_rsp_t  rsp_o
);
  import ftws_pkg::*;

  logic                   busy_q;
  logic [4:0]             cnt_q;
  logic [DivDenWidth-1:0] rem_q;
  logic [DivQWidth-1:0]   low_q;
  logic [DivQWidth-1:0]   quo_q;
  logic [DivDenWidth-1:0] den_q;
  logic                   done_q;
  logic [DivDenWidth:0]   trial;
  logic [DivDenWidth:0]   diff;
  logic                   take;

  assign trial = {rem_q, low_q[DivQWidth-1]};
  assign take  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= req_i.dividend[DivNumWidth-1:DivQWidth];
        low_q  <= req_i.dividend[DivQWidth-1:0];
        den_q  <= req_i.divisor;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? diff[DivDenWidth-1:0] : trial[DivDenWidth-1:0];
        low_q <= {low_q[DivQWidth-2:0], 1'b0};
        quo_q <= {quo_q[DivQWidth-2:0], take};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DivQWidth - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// File: rtl/four_tone_waveform_synth_normalize.sv
// computes the centroid and its divide, reduces the tone steps modulo the frame length,
// builds the frame sample by sample, then normalizes each sample with the shared 16-step
// divider, or without it when the peak does not exceed 16384
// one start transaction at a time; no new transaction until the last sample leaves
// reset restores default tone settings and clears peak and centroid
module four_tone_waveform_synth_normalize #(
  parameter int unsigned FRAME_LENGTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        start_valid_i,
  output logic        start_ready_o,
  input  logic        start_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] sample_value_o,
  output logic [5:0]  sample_index_o,
  output logic        last_sample_o,
  output logic [15:0] mean_frequency_o
);
  import ftws_pkg::*;

  localparam int unsigned IW = $clog2(FRAME_LENGTH);
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  function automatic logic [15:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x = (HalfPiQ30 * 64'(r)) / FRAME_LENGTH;
    t = x;
    s = x;
    t = (((t * x) >> 30) * x) >> 30; t = t / 64'd6;   s = s - t;
    t = (((t * x) >> 30) * x) >> 30; t = t / 64'd20;  s = s + t;
    t = (((t * x) >> 30) * x) >> 30; t = t / 64'd42;  s = s - t;
    t = (((t * x) >> 30) * x) >> 30; t = t / 64'd72;  s = s + t;
    t = (((t * x) >> 30) * x) >> 30; t = t / 64'd110; s = s - t;
    t = (((t * x) >> 30) * x) >> 30; t = t / 64'd156; s = s + t;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

  function automatic logic signed [15:0] sine_at(input int unsigned k);
    int unsigned quad;
    int unsigned rem;
    logic [15:0] mag;
    quad = (4 * k) / FRAME_LENGTH;
    rem  = (4 * k) % FRAME_LENGTH;
    if (quad % 2 == 1) rem = FRAME_LENGTH - rem;
    mag = quarter_sine(rem);
    return (quad >= 2) ? -$signed(mag) : $signed(mag);
  endfunction

  logic signed [15:0] sine_tab [FRAME_LENGTH];
  for (genvar g = 0; g < FRAME_LENGTH; g++) begin : g_tab
    assign sine_tab[g] = sine_at(g);
  end

  typedef enum logic [3:0] {
    S_IDLE, S_CSQ, S_CACC, S_CDIV, S_CDIVW, S_MOD, S_MAC, S_RND,
    S_NRD, S_NDAT, S_NDIVW, S_NSAT, S_NOUT
  } state_e;

  state_e state_q;
  logic [CyclesWidth-1:0] cyc_q  [NumTones];
  logic [GainWidth-1:0]   gain_q [NumTones];
  logic [8:0]             cm_q   [NumTones];
  logic [IW-1:0]          ph_q   [NumTones];
  logic [2:0]             k_q;
  logic [IW-1:0]          i_q;
  logic [29:0]            g2_q;
  logic [32:0]            den_q;
  logic [39:0]            num_q;
  logic [15:0]            cent_q;
  logic signed [31:0]     prod_q;
  logic signed [33:0]     acc_q;
  logic [16:0]            peak_q;
  logic                   neg_q;
  logic [18:0]            raw_q;
  logic                   out_valid_q;
  logic signed [15:0]     val_q;
  logic                   last_q;
  logic [5:0]             idx_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [1:0]             kt;
  logic [33:0]            absacc;
  logic [18:0]            rmag;
  logic [17:0]            cmag;
  logic signed [17:0]     sval;
  logic                   ram_we;
  logic [SampleWidth-1:0] rd_data;
  logic [17:0]            rd_abs;
  logic [IW+5:0]          i_ext;
  logic                   last_i;

  assign kt     = k_q[1:0];
  assign absacc = acc_q[33] ? 34'(-acc_q) : 34'(acc_q);
  assign rmag   = 19'((absacc + 34'd16384) >> 15);
  always_comb begin
    if (acc_q[33]) cmag = (rmag > 19'd131072) ? 18'd131072 : rmag[17:0];
    else           cmag = (rmag > 19'd131071) ? 18'd131071 : rmag[17:0];
  end
  assign sval   = acc_q[33] ? -$signed(cmag) : $signed(cmag);
  assign ram_we = (state_q == S_RND);
  assign rd_abs = rd_data[17] ? 18'(-$signed(rd_data)) : rd_data;
  assign i_ext  = (IW + 6)'(i_q);
  assign last_i = (i_q == IW'(FRAME_LENGTH - 1));

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state_q == S_CDIV && den_q != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = DivNumWidth'({num_q, 8'd0}) + DivNumWidth'(den_q >> 1);
      div_req.divisor  = DivDenWidth'(den_q);
    end else if (state_q == S_NDAT && peak_q > 17'd16384) begin
      div_req.start    = 1'b1;
      div_req.dividend = DivNumWidth'({rd_abs, 16'd0}) + DivNumWidth'(peak_q);
      div_req.divisor  = DivDenWidth'({peak_q, 1'b0});
    end
  end

  ftws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ftws_ram #(
    .Width (SampleWidth),
    .Depth (FRAME_LENGTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (i_q),
    .wdata_i (sval),
    .raddr_i (i_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cyc_q[0]    <= 8'd10;
      cyc_q[1]    <= 8'd20;
      cyc_q[2]    <= 8'd40;
      cyc_q[3]    <= 8'd2;
      for (int t = 0; t < NumTones; t++) gain_q[t] <= 15'd16384;
      k_q         <= '0;
      i_q         <= '0;
      peak_q      <= '0;
      cent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // idx bit 2 selects gains over cycle counts
      if (cfg_we_i) begin
        if (cfg_idx_i[2]) gain_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        else              cyc_q[cfg_idx_i[1:0]]  <= cfg_wdata_i[7:0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_valid_i && start_frame_i) begin
            num_q   <= '0;
            den_q   <= '0;
            k_q     <= '0;
            state_q <= S_CSQ;
          end
        end
        S_CSQ: begin
          g2_q    <= gain_q[kt] * gain_q[kt];
          state_q <= S_CACC;
        end
        S_CACC: begin
          den_q <= den_q + 33'(g2_q);
          num_q <= num_q + 40'(g2_q) * 40'(cyc_q[kt]);
          k_q   <= k_q + 3'd1;
          state_q <= (kt == 2'd3) ? S_CDIV : S_CSQ;
        end
        S_CDIV: begin
          for (int t = 0; t < NumTones; t++) cm_q[t] <= 9'(cyc_q[t]);
          k_q <= '0;
          if (den_q == '0) begin
            cent_q  <= '0;
            state_q <= S_MOD;
          end else begin
            state_q <= S_CDIVW;
          end
        end
        S_CDIVW: begin
          if (div_rsp.done) begin
            cent_q  <= div_rsp.quotient;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (cm_q[kt] >= 9'(FRAME_LENGTH)) begin
            cm_q[kt] <= cm_q[kt] - 9'(FRAME_LENGTH);
          end else begin
            if (kt == 2'd3) begin
              k_q    <= '0;
              i_q    <= '0;
              acc_q  <= '0;
              peak_q <= '0;
              for (int t = 0; t < NumTones; t++) ph_q[t] <= '0;
              state_q <= S_MAC;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        S_MAC: begin
          if (k_q != 3'd4) prod_q <= $signed({1'b0, gain_q[kt]}) * sine_tab[ph_q[kt]];
          if (k_q != 3'd0) acc_q <= acc_q + 34'(prod_q);
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) state_q <= S_RND;
        end
        S_RND: begin
          if (cmag > 18'(peak_q)) peak_q <= (cmag > 18'd131071) ? 17'd131071 : cmag[16:0];
          for (int t = 0; t < NumTones; t++) begin
            if ((IW + 1)'(ph_q[t]) + (IW + 1)'(cm_q[t][IW-1:0]) >= (IW + 1)'(FRAME_LENGTH))
              ph_q[t] <= IW'((IW + 1)'(ph_q[t]) + (IW + 1)'(cm_q[t][IW-1:0])
                             - (IW + 1)'(FRAME_LENGTH));
            else
              ph_q[t] <= ph_q[t] + cm_q[t][IW-1:0];
          end
          k_q   <= '0;
          acc_q <= '0;
          if (last_i) begin
            i_q     <= '0;
            state_q <= S_NRD;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_MAC;
          end
        end
        S_NRD: state_q <= S_NDAT;
        S_NDAT: begin
          neg_q <= rd_data[17];
          if (peak_q > 17'd16384) begin
            state_q <= S_NDIVW;
          end else begin
            raw_q   <= {rd_abs, 1'b0};
            state_q <= S_NSAT;
          end
        end
        S_NDIVW: begin
          if (div_rsp.done) begin
            raw_q   <= 19'(div_rsp.quotient);
            state_q <= S_NSAT;
          end
        end
        S_NSAT: begin
          if (neg_q) val_q <= (raw_q >= 19'd32768) ? -16'sd32768 : -$signed(raw_q[15:0]);
          else       val_q <= (raw_q >= 19'd32767) ? 16'sd32767 : $signed(raw_q[15:0]);
          idx_q       <= i_ext[5:0];
          last_q      <= last_i;
          out_valid_q <= 1'b1;
          state_q     <= S_NOUT;
        end
        S_NOUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_i) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + IW'(1);
              state_q <= S_NRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign start_ready_o    = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign sample_value_o   = val_q;
  assign sample_index_o   = idx_q;
  assign last_sample_o    = last_q;
  assign mean_frequency_o = cent_q;
endmodule
